// ----- sv/lsd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// LSB stego stream decoder package
// Shared widths, register indexes, result kinds and the result structs.
// ----------------------------------------------------------------------------
package lsd_pkg;

    // Largest signature length that the decoder compares.
    localparam int MAGIC_MAX_BYTES = 8;

    // Register index port width and register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_VALUE  = 2'd2;

    // Register reset values: 54 header bytes, two signature characters "#*".
    localparam logic [7:0]  HEADER_BYTES_RST = 8'd54;
    localparam logic [3:0]  MAGIC_LENGTH_RST = 4'd2;
    localparam logic [63:0] MAGIC_VALUE_RST  = 64'h0000_0000_0000_2A23;

    // Kinds of result words.
    typedef enum logic [2:0] {
        KIND_EXT_LEN   = 3'd0,
        KIND_EXT_BYTE  = 3'd1,
        KIND_FILE_LEN  = 3'd2,
        KIND_DATA      = 3'd3,
        KIND_LEN_ERR   = 3'd4,
        KIND_MAGIC_ERR = 3'd5
    } kind_t;

    // Payload of one result word.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic        last;
    } lsd_word_t;

    // Result word with its valid flag, from the decoder core to the top level.
    typedef struct packed {
        logic      valid;
        lsd_word_t word;
    } lsd_res_t;

endpackage : lsd_pkg
`default_nettype wire

// ----- sv/lsd_pix_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Image byte channel
// Valid/ready channel that carries one raw image byte per word.
// ----------------------------------------------------------------------------
interface lsd_pix_if;

    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       start_of_image;

    modport source (output valid, output pixel_byte, output start_of_image, input ready);
    modport sink   (input valid, input pixel_byte, input start_of_image, output ready);

endinterface : lsd_pix_if
`default_nettype wire

// ----- sv/lsd_res_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Decoded result channel
// Valid/ready channel that carries one decoded length, byte or error per word.
// ----------------------------------------------------------------------------
interface lsd_res_if;

    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] value;
    logic        last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);

endinterface : lsd_res_if
`default_nettype wire

// ----- sv/lsd_cfg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Register write channel
// Valid/ready channel that carries a register index and its write data.
// ----------------------------------------------------------------------------
interface lsd_cfg_if import lsd_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface : lsd_cfg_if
`default_nettype wire

// ----- sv/lsb_stego_stream_decoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// LSB stego stream decoder, top level
// Each result word is registered into the output register or the skid stage
// at the edge that accepts its image byte. Throughput: one image byte per
// cycle while the skid stage is free; the two-entry output register and
// skid stage keep input flowing while one result waits to be taken.
// Reset: parse state clears to header skip and the registers return to
// 54 header bytes and the two-character signature "#*"; no clearing pass.
// ----------------------------------------------------------------------------
module lsb_stego_stream_decoder_top
    import lsd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    lsd_pix_if.sink   pix,
    lsd_res_if.source res,
    lsd_cfg_if.sink   cfg
);

    lsd_res_t  core_res;
    logic      in_accept;
    logic      out_take;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    lsd_word_t out_word_reg, out_word_next;
    lsd_word_t skid_word_reg, skid_word_next;

    // Input is taken whenever the skid stage is free.
    assign pix.ready = !skid_valid_reg;
    assign in_accept = pix.valid && pix.ready;
    assign out_take  = res.valid && res.ready;

    lsd_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_accept      (in_accept),
        .pixel_bit      (pix.pixel_byte[0]),
        .start_of_image (pix.start_of_image),
        .result         (core_res)
    );

    // Output register with a skid stage behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;

        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end

        if (core_res.valid)
        begin
            if (!out_valid_next)
            begin
                out_word_next  = core_res.word;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_word_next  = core_res.word;
                skid_valid_next = 1'b1;
            end
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payloads.
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign res.valid = out_valid_reg;
    assign res.kind  = out_word_reg.kind;
    assign res.value = out_word_reg.value;
    assign res.last  = out_word_reg.last;

`ifndef ASSERT_OFF
    // The skid stage only holds a word behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // A new result against a stalled output lands in the skid stage.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (core_res.valid && out_valid_reg && !res.ready) |=> skid_valid_reg)
        else $error("result lost against stalled output");

    // A waiting result word holds steady until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> (res.valid && $stable(out_word_reg)))
        else $error("result word changed while waiting");
`endif

endmodule : lsb_stego_stream_decoder_top
`default_nettype wire

// ----- sv/lsd_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// LSB stego decoder core
// Holds the registers and the parse state, and turns each accepted image
// byte into at most one result word in the same cycle.
// ----------------------------------------------------------------------------
module lsd_core
    import lsd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lsd_cfg_if.sink    cfg,
    input  wire logic  in_accept,
    input  wire logic  pixel_bit,
    input  wire logic  start_of_image,
    output lsd_res_t   result
);

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_MLEN   = 3'd1,
        PH_MBYTES = 3'd2,
        PH_ELEN   = 3'd3,
        PH_EBYTES = 3'd4,
        PH_FLEN   = 3'd5,
        PH_DATA   = 3'd6,
        PH_DONE   = 3'd7
    } phase_t;

    logic [7:0]  header_bytes_reg;
    logic [3:0]  magic_length_reg;
    logic [63:0] magic_value_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  skip_count_reg, skip_count_next;
    logic [4:0]  bit_count_reg, bit_count_next;
    logic [31:0] bit_shift_reg, bit_shift_next;
    logic [31:0] items_left_reg, items_left_next;
    logic [3:0]  magic_index_reg, magic_index_next;
    logic        magic_bad_reg, magic_bad_next;

    phase_t      phase_cur;
    phase_t      work_phase;
    logic [7:0]  skip_cur;
    logic [4:0]  bit_count_cur;
    logic [31:0] bit_shift_cur;
    logic [31:0] items_left_cur;
    logic [3:0]  magic_index_cur;
    logic        magic_bad_cur;
    logic [31:0] word;
    logic [31:0] items_dec;
    logic [7:0]  expect_byte;
    logic        need_wide;
    logic        word_full;
    logic        proceed;
    logic        bad_now;

    // The write channel never stalls.
    assign cfg.ready = 1'b1;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bytes_reg <= HEADER_BYTES_RST;
            magic_length_reg <= MAGIC_LENGTH_RST;
            magic_value_reg  <= MAGIC_VALUE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_HEADER_BYTES: header_bytes_reg <= cfg.data[7:0];
                CFG_MAGIC_LENGTH: magic_length_reg <= cfg.data[3:0];
                CFG_MAGIC_VALUE:  magic_value_reg  <= cfg.data;
                default:          ;
            endcase
        end
    end

    // Start of image clears the parse state before this byte is used.
    always_comb
    begin
        if (start_of_image)
        begin
            phase_cur       = PH_SKIP;
            skip_cur        = '0;
            bit_count_cur   = '0;
            bit_shift_cur   = '0;
            items_left_cur  = '0;
            magic_index_cur = '0;
            magic_bad_cur   = 1'b0;
        end
        else
        begin
            phase_cur       = phase_reg;
            skip_cur        = skip_count_reg;
            bit_count_cur   = bit_count_reg;
            bit_shift_cur   = bit_shift_reg;
            items_left_cur  = items_left_reg;
            magic_index_cur = magic_index_reg;
            magic_bad_cur   = magic_bad_reg;
        end
    end

    // Bit gathering and field parsing for one accepted byte.
    always_comb
    begin
        phase_next       = phase_reg;
        skip_count_next  = skip_count_reg;
        bit_count_next   = bit_count_reg;
        bit_shift_next   = bit_shift_reg;
        items_left_next  = items_left_reg;
        magic_index_next = magic_index_reg;
        magic_bad_next   = magic_bad_reg;
        result           = '0;
        proceed          = 1'b0;

        // Leaving the header skip starts the signature length field.
        work_phase = (phase_cur == PH_SKIP) ? PH_MLEN : phase_cur;
        word       = {bit_shift_cur[30:0], pixel_bit};
        need_wide  = (work_phase == PH_MLEN) || (work_phase == PH_ELEN) ||
                     (work_phase == PH_FLEN);
        word_full  = need_wide ? (bit_count_cur == 5'd31) : (bit_count_cur == 5'd7);
        items_dec  = items_left_cur - 32'd1;
        expect_byte = magic_value_reg[{magic_index_cur[2:0], 3'b000} +: 8];
        bad_now    = magic_bad_cur || (expect_byte != word[7:0]);

        if (in_accept)
        begin
            phase_next       = phase_cur;
            skip_count_next  = skip_cur;
            bit_count_next   = bit_count_cur;
            bit_shift_next   = bit_shift_cur;
            items_left_next  = items_left_cur;
            magic_index_next = magic_index_cur;
            magic_bad_next   = magic_bad_cur;

            if (phase_cur == PH_SKIP)
            begin
                if (skip_cur < header_bytes_reg)
                begin
                    skip_count_next = skip_cur + 8'd1;
                end
                else
                begin
                    proceed = 1'b1;
                end
            end
            else if (phase_cur != PH_DONE)
            begin
                proceed = 1'b1;
            end

            if (proceed && !word_full)
            begin
                phase_next     = work_phase;
                bit_count_next = bit_count_cur + 5'd1;
                bit_shift_next = word;
            end
            else if (proceed)
            begin
                bit_count_next = '0;
                bit_shift_next = '0;
                case (work_phase)
                    PH_MLEN:
                    begin
                        if ((magic_length_reg > 4'(MAGIC_MAX_BYTES)) ||
                            (word != {28'd0, magic_length_reg}))
                        begin
                            phase_next        = PH_DONE;
                            result.valid      = 1'b1;
                            result.word.kind  = KIND_LEN_ERR;
                            result.word.last  = 1'b1;
                        end
                        else
                        begin
                            magic_index_next = '0;
                            magic_bad_next   = 1'b0;
                            items_left_next  = {28'd0, magic_length_reg};
                            phase_next = (magic_length_reg == 4'd0) ? PH_ELEN : PH_MBYTES;
                        end
                    end
                    PH_MBYTES:
                    begin
                        magic_bad_next   = bad_now;
                        magic_index_next = magic_index_cur + 4'd1;
                        items_left_next  = items_dec;
                        if (items_dec == 32'd0)
                        begin
                            if (bad_now)
                            begin
                                phase_next       = PH_DONE;
                                result.valid     = 1'b1;
                                result.word.kind = KIND_MAGIC_ERR;
                                result.word.last = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_ELEN;
                            end
                        end
                    end
                    PH_ELEN:
                    begin
                        items_left_next   = word;
                        phase_next        = (word != 32'd0) ? PH_EBYTES : PH_FLEN;
                        result.valid      = 1'b1;
                        result.word.kind  = KIND_EXT_LEN;
                        result.word.value = word;
                    end
                    PH_EBYTES:
                    begin
                        items_left_next = items_dec;
                        if (items_dec == 32'd0)
                        begin
                            phase_next = PH_FLEN;
                        end
                        result.valid      = 1'b1;
                        result.word.kind  = KIND_EXT_BYTE;
                        result.word.value = {24'd0, word[7:0]};
                    end
                    PH_FLEN:
                    begin
                        items_left_next   = word;
                        phase_next        = (word != 32'd0) ? PH_DATA : PH_DONE;
                        result.valid      = 1'b1;
                        result.word.kind  = KIND_FILE_LEN;
                        result.word.value = word;
                        result.word.last  = (word == 32'd0);
                    end
                    PH_DATA:
                    begin
                        items_left_next = items_dec;
                        if (items_dec == 32'd0)
                        begin
                            phase_next = PH_DONE;
                        end
                        result.valid      = 1'b1;
                        result.word.kind  = KIND_DATA;
                        result.word.value = {24'd0, word[7:0]};
                        result.word.last  = (items_dec == 32'd0);
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    // Parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SKIP;
            skip_count_reg  <= '0;
            bit_count_reg   <= '0;
            bit_shift_reg   <= '0;
            items_left_reg  <= '0;
            magic_index_reg <= '0;
            magic_bad_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            skip_count_reg  <= skip_count_next;
            bit_count_reg   <= bit_count_next;
            bit_shift_reg   <= bit_shift_next;
            items_left_reg  <= items_left_next;
            magic_index_reg <= magic_index_next;
            magic_bad_reg   <= magic_bad_next;
        end
    end

`ifndef ASSERT_OFF
    // No hidden bits are gathered while the header is being skipped.
    a_skip_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> ((bit_count_reg == 5'd0) && (bit_shift_reg == 32'd0)))
        else $error("bits gathered during header skip");

    // The signature index never runs past the longest signature.
    a_magic_index: assert property (@(posedge clk) disable iff (!rst_n)
        magic_index_reg <= 4'(MAGIC_MAX_BYTES))
        else $error("signature index out of range");

    // A final result or an error leaves the parser idle.
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.word.last) |=> (phase_reg == PH_DONE))
        else $error("parser not idle after final result");
`endif

endmodule : lsd_core
`default_nettype wire
